// File: rtl/eutd_pkg.sv
// ============================================================================
// eutd_pkg: shared types for the Euler totient trial-division block
// Holds the default field width, the sequencer states and the divider
// handshake structs.
// ============================================================================
package eutd_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUND,
    ST_INNER,
    ST_ACC,
    ST_FINAL,
    ST_DONE
  } eutd_state_e;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

// File: rtl/eutd_divider.sv
// ============================================================================
// eutd_divider: restoring radix-2 unsigned divider
// Produces quotient and remainder one bit per cycle.
// ============================================================================
module eutd_divider import eutd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  div_req_t               req_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [VALUE_WIDTH-1:0] divisor_i,
  output div_rsp_t               rsp_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [VALUE_WIDTH-1:0] remainder_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH + 1);

  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [VALUE_WIDTH-1:0] rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [VALUE_WIDTH-1:0] div_q, div_d;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   diff;
  logic                   busy;

  assign busy  = (cnt_q != '0);
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (req_i.start) begin
      cnt_d = CntWidth'(VALUE_WIDTH);
      rem_d = '0;
      quo_d = dividend_i;
      div_d = divisor_i;
    end else if (busy) begin
      // Keep the trial value when the subtraction would go negative.
      rem_d  = diff[VALUE_WIDTH] ? trial[VALUE_WIDTH-1:0] : diff[VALUE_WIDTH-1:0];
      quo_d  = {quo_q[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
      cnt_d  = cnt_q - CntWidth'(1);
      done_d = (cnt_q == CntWidth'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign rsp_o.busy  = busy;
  assign rsp_o.done  = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/euler_totient_trial_division.sv
// ============================================================================
// euler_totient_trial_division: Euler totient by trial division
// Takes one unsigned value and returns its totient, dividing out each prime
// factor with a shared iterative divider.
// ============================================================================
// Each candidate d costs one division on the shared divider; a factor d
// also costs one division per power of d divided out and one to reduce
// the running result.
// Throughput: one item at a time; the next transfer is taken once the result
// sits in the output register. Reset clears the sequencer and output valid.

module euler_totient_trial_division import eutd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata fields from bit 0 up: value, then zero padding to a whole byte.
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata fields from bit 0 up: totient, then zero padding to a whole byte.
  output logic [((VALUE_WIDTH+7)/8)*8-1:0]    m_axis_tdata_o
);

  localparam int unsigned DataWidth = ((VALUE_WIDTH + 7) / 8) * 8;

  eutd_state_e state_q, state_d;

  // rest_q is the cofactor still to be factored, acc_q the running totient
  // and cand_q the trial divisor.
  logic [VALUE_WIDTH-1:0] rest_q, rest_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [VALUE_WIDTH-1:0] cand_q, cand_d;
  logic [VALUE_WIDTH-1:0] out_q, out_d;
  logic                   out_vld_q, out_vld_d;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [VALUE_WIDTH-1:0] div_a, div_b;
  logic [VALUE_WIDTH-1:0] div_quo, div_rem;

  eutd_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (div_req),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .rsp_o       (div_rsp),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Sequencer. In ST_BOUND the division rest / d serves both the loop bound
  // (d <= rest / d) and the divisibility test. ST_INNER keeps dividing out
  // the same factor; ST_ACC applies acc -= acc / d; ST_FINAL applies the
  // leftover prime cofactor.
  always_comb begin
    state_d       = state_q;
    rest_d        = rest_q;
    acc_d         = acc_q;
    cand_d        = cand_q;
    out_d         = out_q;
    out_vld_d     = out_vld_q;
    div_req.start = 1'b0;
    div_a         = rest_q;
    div_b         = cand_q;

    if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          rest_d        = s_axis_tdata_i[VALUE_WIDTH-1:0];
          acc_d         = s_axis_tdata_i[VALUE_WIDTH-1:0];
          cand_d        = VALUE_WIDTH'(2);
          div_a         = s_axis_tdata_i[VALUE_WIDTH-1:0];
          div_b         = VALUE_WIDTH'(2);
          div_req.start = 1'b1;
          state_d       = ST_BOUND;
        end
      end
      ST_BOUND: begin
        if (div_rsp.done) begin
          if (cand_q > div_quo) begin
            // No candidate left; a cofactor above one is itself prime.
            if (rest_q > VALUE_WIDTH'(1)) begin
              div_a         = acc_q;
              div_b         = rest_q;
              div_req.start = 1'b1;
              state_d       = ST_FINAL;
            end else begin
              state_d = ST_DONE;
            end
          end else if (div_rem == '0) begin
            rest_d        = div_quo;
            div_a         = div_quo;
            div_b         = cand_q;
            div_req.start = 1'b1;
            state_d       = ST_INNER;
          end else begin
            cand_d        = cand_q + VALUE_WIDTH'(1);
            div_a         = rest_q;
            div_b         = cand_q + VALUE_WIDTH'(1);
            div_req.start = 1'b1;
          end
        end
      end
      ST_INNER: begin
        if (div_rsp.done) begin
          if (div_rem == '0) begin
            rest_d        = div_quo;
            div_a         = div_quo;
            div_b         = cand_q;
            div_req.start = 1'b1;
          end else begin
            div_a         = acc_q;
            div_b         = cand_q;
            div_req.start = 1'b1;
            state_d       = ST_ACC;
          end
        end
      end
      ST_ACC: begin
        if (div_rsp.done) begin
          acc_d         = acc_q - div_quo;
          cand_d        = cand_q + VALUE_WIDTH'(1);
          div_a         = rest_q;
          div_b         = cand_q + VALUE_WIDTH'(1);
          div_req.start = 1'b1;
          state_d       = ST_BOUND;
        end
      end
      ST_FINAL: begin
        if (div_rsp.done) begin
          acc_d   = acc_q - div_quo;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free, then hand the result over.
        if (!out_vld_q || m_axis_tready_i) begin
          out_d     = acc_q;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
    acc_q  <= acc_d;
    cand_q <= cand_d;
    out_q  <= out_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = DataWidth'(out_q);

`ifndef SYNTHESIS
  // A new division is never started while the divider is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  // A finished division only arrives while the sequencer waits for one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_BOUND || state_q == ST_INNER ||
                      state_q == ST_ACC || state_q == ST_FINAL))
    else $error("division result outside a waiting state");

  // The trial divisor never drops below two while factoring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BOUND || state_q == ST_INNER || state_q == ST_ACC)
      |-> cand_q >= VALUE_WIDTH'(2))
    else $error("trial divisor below two");

  // A waiting result is not overwritten before it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(out_q))
    else $error("pending result overwritten");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for euler_totient_trial_division
// Sends values over the input stream, works out each totient with its own
// trial-division predictor, and compares every output transfer against the
// oldest pending prediction. The sender runs in bursts and the receiver
// stalls in its own pattern.
// ============================================================================
module tb_top;
  import eutd_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH_DEF;
  localparam int unsigned TDW = ((W + 7) / 8) * 8;
  localparam logic [63:0] FIELD_MAX = (64'd1 << W) - 64'd1;
  localparam int unsigned SMOOTH_PRIMES [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

  typedef struct {
    logic [W-1:0] value;
    logic [W-1:0] totient;
  } phi_item_t;

  logic           clk_i     = 1'b0;
  logic           rst_ni    = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  logic [TDW-1:0] in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [TDW-1:0] out_data;

  phi_item_t   pending_totients [$];
  phi_item_t   oldest;
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  int unsigned ready_run      = 0;

  euler_totient_trial_division #(
    .VALUE_WIDTH(W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_data),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Totient by trial division: strip each factor d completely, then reduce
  // the running result by result / d. A cofactor left above 1 is prime.
  function automatic logic [W-1:0] phi_by_trial(input logic [W-1:0] n);
    logic [63:0] rest;
    logic [63:0] acc;
    logic [63:0] d;
    rest = 64'(n);
    acc  = 64'(n);
    for (d = 64'd2; d <= rest / d; d++) begin
      if (rest % d == 64'd0) begin
        while (rest % d == 64'd0) rest = rest / d;
        acc = acc - acc / d;
      end
    end
    if (rest > 64'd1) acc = acc - acc / rest;
    return acc[W-1:0];
  endfunction

  // Product of random small primes, kept inside the field. These values set
  // the high bits while the block strips them quickly.
  function automatic logic [W-1:0] smooth_value();
    logic [63:0] acc;
    logic [63:0] p;
    int          k;
    acc = 64'd1;
    for (k = 0; k < 40; k++) begin
      p = 64'(SMOOTH_PRIMES[$urandom_range(0, 9)]);
      if (acc * p > FIELD_MAX) break;
      acc = acc * p;
      if ($urandom_range(0, 15) == 0) break;
    end
    return acc[W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // One input transfer. A new burst starts after a gap with valid low,
  // so valid is never lowered and raised in the same step.
  task automatic send_value(input logic [TDW-1:0] word);
    int unsigned gap;
    phi_item_t   item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk_i); while (!in_ready);
    burst_left--;
    item.value   = word[W-1:0];
    item.totient = phi_by_trial(word[W-1:0]);
    pending_totients = {pending_totients, item};
  endtask

  // Hold the sender off until every pending totient has come back.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_totients.size() != 0);
  endtask

  task automatic test_special_values();
    send_value(TDW'(0));
    send_value(TDW'(1));
    send_value(TDW'(2));
    send_value(TDW'(3));
    send_value(TDW'(4));
    // The padding bit above the field must be ignored.
    send_value(TDW'(6) | (TDW'(1) << (TDW - 1)));
    send_value(TDW'(49));
    send_value(TDW'(961));
    send_value(TDW'(1024));
    send_value(TDW'(65537));
    send_value(TDW'(92674));
    send_value(TDW'(223092870));
    send_value(TDW'(1073741824));
    send_value(TDW'(1162261467));
    send_value(TDW'(715827882));
    send_value(TDW'(1431655765));
    send_value(TDW'(2147483646));
  endtask

  task automatic test_small_random();
    logic [TDW-1:0] word;
    int             k;
    for (k = 0; k < 55; k++) begin
      case ($urandom_range(0, 9))
        0:       word = TDW'($urandom_range(4096, 65535));
        1, 2, 3: word = TDW'($urandom_range(0, 255));
        default: word = TDW'($urandom_range(0, 4095));
      endcase
      if ($urandom_range(0, 7) == 0) word[TDW-1] = 1'b1;
      send_value(word);
    end
  endtask

  task automatic test_smooth_random();
    int k;
    for (k = 0; k < 28; k++) send_value(TDW'(smooth_value()));
  endtask

  // A fully random word usually keeps a large prime cofactor: slow, so once.
  task automatic test_wide_random();
    send_value(TDW'($urandom()));
  endtask

  // The field maximum is a prime, the slowest case the block has.
  task automatic test_largest_prime();
    send_value(TDW'(FIELD_MAX));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    wait_all_results();
    test_small_random();
    test_smooth_random();
    wait_all_results();
    test_wide_random();
    test_largest_prime();
    wait_all_results();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("euler_totient_trial_division verification clean");
    end else begin
      $display("euler_totient_trial_division verification failed");
    end
    $finish;
  end

  // Receiver: long ready stretches, long stalls and short random flicker.
  always @(posedge clk_i) begin
    if (ready_run == 0) begin
      case ($urandom_range(0, 3))
        0: begin
          out_ready <= 1'b1;
          ready_run <= $urandom_range(50, 200);
        end
        1: begin
          out_ready <= 1'b0;
          ready_run <= $urandom_range(1, 40);
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_run <= $urandom_range(1, 6);
        end
      endcase
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // Output transfers are checked in order against the pending totients.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_totients.size() == 0) begin
        report_mismatch($sformatf("unexpected result, totient %0d", out_data[W-1:0]));
      end else begin
        oldest = pending_totients.pop_front();
        if (out_data[W-1:0] !== oldest.totient) begin
          report_mismatch($sformatf("value %0d: totient %0d, predicted %0d",
                                    oldest.value, out_data[W-1:0], oldest.totient));
        end
      end
    end
  end

  // A watchdog that allows several times the slowest correct run.
  initial begin
    #(64'd400_000_000);
    $display("euler_totient_trial_division verification failed");
    $finish;
  end

endmodule
